>>> rtl/hcbp_pkg.sv
package hcbp_pkg;

  // Number of code table entries: 256 data symbols plus the end-of-stream code.
  localparam int unsigned TableEntries = 257;
  localparam int unsigned EntryIdxW    = 9;
  localparam int unsigned CodeBitsW    = 32;
  localparam int unsigned ByteW        = 8;
  localparam logic [EntryIdxW-1:0] EndSymbol = 9'd256;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_END    = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_PACK
  } state_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [EntryIdxW-1:0] entry_index;
    logic [5:0]           code_len;
    logic [CodeBitsW-1:0] code_bits;
    logic [ByteW-1:0]     data_byte;
  } req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             no_data;
  } res_t;

endpackage

>>> rtl/huffman_code_bit_packer_core.sv
// Table-driven Huffman encoder with a byte packer.
// Input channel: a beat on req_i is taken at a rising edge where start is high and
// busy is low. A load beat writes one code table entry in that same edge and never
// raises busy, so loads can be issued every cycle while busy is low. An encode beat
// looks up the code of data_byte; an end beat looks up the end-of-stream code (entry
// 256) and then flushes a partial byte padded with zeros, marking its final result
// with last. Result channel: each beat on res_o is valid for exactly one cycle while
// out_valid_o is high; the receiver cannot stall, so nothing waits for it.
// Timing: an encode or end beat keeps busy high from its accepting edge through the
// lookup state and the packing steps. The table is read at the accepting edge; the
// lookup state unpacks the entry. Each packing step moves up to eight code bits
// into the byte accumulator and can complete at most one byte. An end beat adds one
// step for the flush or the empty-end result unless its last code bit completes a
// byte. Results are registered and appear in the cycle after the step that forms
// them. Reset clears the accumulator, the bit count and the control state. The table
// is not cleared; an entry must be loaded before it is used.
module huffman_code_bit_packer_core #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hcbp_pkg::req_t    req_i,
  output logic              out_valid_o,
  output hcbp_pkg::res_t    res_o
);

  // Stored length width and table entry width.
  localparam int unsigned LenW   = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned EntryW = LenW + hcbp_pkg::CodeBitsW;

  hcbp_pkg::state_e state_q, state_d;

  // Code table: length in the upper bits, right-aligned code below.
  logic [EntryW-1:0] table_mem [hcbp_pkg::TableEntries];
  logic [EntryW-1:0] rd_data_q;
  logic [hcbp_pkg::EntryIdxW-1:0] rd_addr;

  logic accept;
  logic load_wr;
  logic [LenW-1:0] len_clamped;

  // Working registers of the item in flight.
  logic [hcbp_pkg::CodeBitsW-1:0] code_q, code_d;
  logic [LenW-1:0]                rem_q, rem_d;
  logic                           is_end_q, is_end_d;

  // Bit accumulator: pend_q valid bits, right-aligned, newest in bit 0.
  logic [6:0] acc_q, acc_d;
  logic [2:0] pend_q, pend_d;

  logic            out_valid_q, out_valid_d;
  hcbp_pkg::res_t  out_q, out_d;

  // Packing step signals.
  logic [3:0]                     room;
  logic [3:0]                     take;
  logic [LenW-1:0]                rem_next;
  logic [hcbp_pkg::CodeBitsW-1:0] chunk_w;
  logic [7:0]                     chunk;
  logic [8:0]                     mask_w;
  logic [15:0]                    acc_shift;
  logic [7:0]                     acc_full;
  logic [3:0]                     pend_sum;
  logic                           byte_done;
  logic [15:0]                    pad_shift;

  assign accept = start && !busy;
  assign busy   = (state_q != hcbp_pkg::S_IDLE);

  assign load_wr = accept && (req_i.req_type == hcbp_pkg::REQ_LOAD)
                   && (req_i.entry_index < hcbp_pkg::EntryIdxW'(hcbp_pkg::TableEntries));

  assign len_clamped = (32'(req_i.code_len) > MAX_CODE_LEN) ? LenW'(MAX_CODE_LEN)
                                                             : LenW'(req_i.code_len);

  assign rd_addr = (req_i.req_type == hcbp_pkg::REQ_ENCODE)
                   ? {1'b0, req_i.data_byte} : hcbp_pkg::EndSymbol;

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      table_mem[req_i.entry_index] <= {len_clamped, req_i.code_bits};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= table_mem[rd_addr];
  end

  // One packing step: take as many code bits as fit in the current byte.
  always_comb begin
    room      = 4'd8 - {1'b0, pend_q};
    take      = (rem_q < LenW'(room)) ? 4'(rem_q) : room;
    rem_next  = rem_q - LenW'(take);
    chunk_w   = code_q >> rem_next;
    mask_w    = (9'd1 << take) - 9'd1;
    chunk     = chunk_w[7:0] & mask_w[7:0];
    acc_shift = {9'b0, acc_q} << take;
    acc_full  = acc_shift[7:0] | chunk;
    pend_sum  = {1'b0, pend_q} + take;
    byte_done = (pend_sum == 4'd8);
    pad_shift = {9'b0, acc_q} << room;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcbp_pkg::S_IDLE: begin
        if (accept && ((req_i.req_type == hcbp_pkg::REQ_ENCODE) ||
                       (req_i.req_type == hcbp_pkg::REQ_END))) begin
          state_d = hcbp_pkg::S_LOOKUP;
        end
      end
      hcbp_pkg::S_LOOKUP: begin
        state_d = hcbp_pkg::S_PACK;
      end
      hcbp_pkg::S_PACK: begin
        if (rem_q == '0) begin
          state_d = hcbp_pkg::S_IDLE;
        end else if ((rem_next == '0) && (!is_end_q || byte_done)) begin
          state_d = hcbp_pkg::S_IDLE;
        end
      end
      default: state_d = hcbp_pkg::S_IDLE;
    endcase
  end

  // Datapath and result outputs.
  always_comb begin
    code_d      = code_q;
    rem_d       = rem_q;
    is_end_d    = is_end_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    unique case (state_q)
      hcbp_pkg::S_IDLE: begin
        if (accept) begin
          is_end_d = (req_i.req_type == hcbp_pkg::REQ_END);
        end
      end
      hcbp_pkg::S_LOOKUP: begin
        rem_d  = rd_data_q[EntryW-1:hcbp_pkg::CodeBitsW];
        code_d = rd_data_q[hcbp_pkg::CodeBitsW-1:0];
      end
      hcbp_pkg::S_PACK: begin
        if (rem_q == '0) begin
          // Only an end item gets here with work left: flush or report empty.
          if (is_end_q) begin
            out_valid_d   = 1'b1;
            out_d.out_byte = (pend_q == 3'd0) ? 8'd0 : pad_shift[7:0];
            out_d.last    = 1'b1;
            out_d.no_data = (pend_q == 3'd0);
            acc_d         = '0;
            pend_d        = '0;
          end
        end else begin
          rem_d = rem_next;
          if (byte_done) begin
            out_valid_d    = 1'b1;
            out_d.out_byte = acc_full;
            out_d.last     = is_end_q && (rem_next == '0);
            out_d.no_data  = 1'b0;
            acc_d          = '0;
            pend_d         = '0;
          end else begin
            acc_d  = acc_full[6:0];
            pend_d = pend_sum[2:0];
          end
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcbp_pkg::S_IDLE;
      acc_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    rem_q    <= rem_d;
    is_end_q <= is_end_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // The accumulator never holds stray bits above its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd0) |-> (acc_q == 7'd0))
    else $error("accumulator holds bits while count is zero");

  // Results come only from a packing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(state_q == hcbp_pkg::S_PACK))
    else $error("result strobe outside a packing step");

  // An empty end result carries last and a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.no_data) |-> (out_q.last && (out_q.out_byte == 8'd0)))
    else $error("no_data result malformed");

  // After the final result of an end item the packer is empty and idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> ((pend_q == 3'd0) && (state_q == hcbp_pkg::S_IDLE)))
    else $error("packer not empty after end of stream");

  // A load never makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == hcbp_pkg::REQ_LOAD)) |=> !busy)
    else $error("load raised busy");

endmodule

>>> tb/huffman_code_bit_packer_core_tb.sv
module huffman_code_bit_packer_core_tb;

  // The block clamps longer codes to this length; the instance uses the same value.
  localparam int unsigned CodeLenMax = 32;
  // Request code 3 has no enum member; the block must ignore it.
  localparam logic [1:0] ReqUnused  = 2'd3;
  // Random beats that actually do something (ignored beats do not count).
  localparam int RandBeats    = 210;
  // No idle gaps for the last stretch of the random stream.
  localparam int QuietTail    = 30;
  // Extra cycles after the last expected byte.
  localparam int DrainCycles  = 16;
  localparam int CycleLimit   = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  hcbp_pkg::req_t req_q = '0;
  logic out_valid_o;
  hcbp_pkg::res_t res_o;

  // One beat waiting to be driven. A drain beat is held back until every byte
  // predicted so far has come out; quiet beats never get an idle gap before them.
  typedef struct {
    hcbp_pkg::req_t req;
    bit   drain;
    bit   quiet;
  } pending_beat_t;

  pending_beat_t  beat_queue[$];
  hcbp_pkg::res_t expected_bytes[$];

  // Predicted encoder state: the code table and the partial output byte.
  logic [5:0]  tbl_len [0:hcbp_pkg::TableEntries-1];
  logic [31:0] tbl_code[0:hcbp_pkg::TableEntries-1];
  logic [7:0]  acc = '0;
  int          acc_bits = 0;

  // What the stimulus side knows has been loaded, so that no unloaded entry is read.
  bit entry_loaded[0:hcbp_pkg::TableEntries-1];
  int loaded_syms[$];

  int mismatches = 0;
  int cycle_count = 0;
  // The monitor counts taken beats; the driver keeps the count it has seen.
  int beats_taken = 0;
  int beats_seen = 0;
  int idle_left = 0;
  bit gap_rolled = 1'b0;

  huffman_code_bit_packer_core #(
    .MAX_CODE_LEN(CodeLenMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_q),
    .out_valid_o(out_valid_o),
    .res_o      (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Shift the code of one table entry into the accumulator, most significant code
  // bit first, and emit a byte each time eight bits have gathered.
  task automatic pack_code(input int sym);
    int             i;
    hcbp_pkg::res_t full;
    for (i = int'(tbl_len[sym]); i > 0; i--) begin
      acc = {acc[6:0], tbl_code[sym][i-1]};
      acc_bits++;
      if (acc_bits == 8) begin
        full.out_byte = acc;
        full.last     = 1'b0;
        full.no_data  = 1'b0;
        expected_bytes.push_back(full);
        acc      = '0;
        acc_bits = 0;
      end
    end
  endtask

  task automatic predict_beat(input hcbp_pkg::req_t r);
    int             first_new;
    int             len;
    hcbp_pkg::res_t tail;
    if (r.req_type == hcbp_pkg::REQ_LOAD) begin
      // Loads past the end of the table are dropped; long codes are clamped.
      if (r.entry_index < hcbp_pkg::TableEntries) begin
        len = int'(r.code_len);
        if (len > CodeLenMax) len = CodeLenMax;
        tbl_len[r.entry_index]  = len[5:0];
        tbl_code[r.entry_index] = r.code_bits;
      end
    end else if (r.req_type == hcbp_pkg::REQ_ENCODE) begin
      pack_code(int'(r.data_byte));
    end else if (r.req_type == hcbp_pkg::REQ_END) begin
      first_new = expected_bytes.size();
      pack_code(int'(hcbp_pkg::EndSymbol));
      // Any pending bits go out, zero padded, even when all of them are zero.
      if (acc_bits > 0) begin
        tail.out_byte = acc << (8 - acc_bits);
        tail.last     = 1'b0;
        tail.no_data  = 1'b0;
        expected_bytes.push_back(tail);
        acc      = '0;
        acc_bits = 0;
      end
      if (expected_bytes.size() == first_new) begin
        // Nothing to emit: a single empty marker beat.
        tail.out_byte = '0;
        tail.last     = 1'b1;
        tail.no_data  = 1'b1;
        expected_bytes.push_back(tail);
      end else begin
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
      end
    end
    // Request code 3 changes nothing.
  endtask

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Fields that a request type does not use still carry random values, so every
  // input bit toggles.
  function automatic hcbp_pkg::req_t random_req(input logic [1:0] kind);
    hcbp_pkg::req_t r;
    r.req_type    = kind;
    r.entry_index = 9'($urandom_range(0, 511));
    r.code_len    = 6'($urandom_range(0, 63));
    r.code_bits   = $urandom;
    r.data_byte   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic int random_code_len();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return 0;
    if (roll < 12) return $urandom_range(1, 12);
    if (roll < 19) return $urandom_range(13, 32);
    return $urandom_range(33, 63);
  endfunction

  task automatic queue_raw(input hcbp_pkg::req_t r, input bit drain, input bit quiet);
    pending_beat_t p;
    p.req   = r;
    p.drain = drain;
    p.quiet = quiet;
    beat_queue.push_back(p);
  endtask

  task automatic queue_load(input int idx, input int len, input logic [31:0] bits,
                            input bit drain, input bit quiet);
    hcbp_pkg::req_t r;
    r = random_req(hcbp_pkg::REQ_LOAD);
    r.entry_index = idx[8:0];
    r.code_len    = len[5:0];
    r.code_bits   = bits;
    if (idx < hcbp_pkg::TableEntries && !entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      if (idx < 256) loaded_syms.push_back(idx);
    end
    queue_raw(r, drain, quiet);
  endtask

  task automatic queue_encode(input int sym, input bit drain, input bit quiet);
    hcbp_pkg::req_t r;
    r = random_req(hcbp_pkg::REQ_ENCODE);
    r.data_byte = sym[7:0];
    queue_raw(r, drain, quiet);
  endtask

  task automatic queue_end(input bit drain, input bit quiet);
    queue_raw(random_req(hcbp_pkg::REQ_END), drain, quiet);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one beat at a time and holds it until the block takes it.
  // Inputs only change on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic          nxt_start;
    pending_beat_t p;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && (beats_taken != beats_seen)) nxt_start = 1'b0;
      beats_seen = beats_taken;
      if (!nxt_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (beat_queue.size() > 0 &&
                     !(beat_queue[0].drain && expected_bytes.size() != 0)) begin
          // Roll once per beat for an idle burst; the burst includes this cycle.
          if (!beat_queue[0].quiet && !gap_rolled && $urandom_range(0, 4) == 0) begin
            idle_left  = $urandom_range(1, 17) - 1;
            gap_rolled = 1'b1;
          end else begin
            p = beat_queue.pop_front();
            req_q     <= p.req;
            nxt_start = 1'b1;
            gap_rolled = 1'b0;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge check an output beat against the oldest
  // prediction, then predict the results of an input beat taken at this edge.
  // Checking first keeps older expectations ahead of the new ones.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hcbp_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected beat byte %02h last %0b no_data %0b",
                                  res_o.out_byte, res_o.last, res_o.no_data));
        end else begin
          want = expected_bytes.pop_front();
          if (res_o.out_byte !== want.out_byte || res_o.last !== want.last ||
              res_o.no_data !== want.no_data) begin
            note_mismatch($sformatf(
              "byte %02h/%02h last %0b/%0b no_data %0b/%0b (expected/actual)",
              want.out_byte, res_o.out_byte, want.last, res_o.last,
              want.no_data, res_o.no_data));
          end
        end
      end
      if (start && !busy) begin
        predict_beat(req_q);
        beats_taken++;
      end
    end
  end

  // Hard stop in case the block hangs or never drops busy.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------
  initial begin
    int             counted;
    int             roll;
    bit             quiet;
    bit             drain;
    hcbp_pkg::req_t r;

    for (int k = 0; k < hcbp_pkg::TableEntries; k++) begin
      tbl_len[k]      = '0;
      tbl_code[k]     = '0;
      entry_loaded[k] = 1'b0;
    end

    // Directed part. Upper code bits beyond the length carry random junk.
    queue_load(0, 8, {24'($urandom_range(0, 16777215)), 8'hA5}, 1'b0, 1'b0);
    queue_load(255, 32, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_load(1, 0, $urandom, 1'b0, 1'b0);       // zero-length code
    queue_load(2, 63, $urandom, 1'b0, 1'b0);      // overlong code, clamped
    queue_load(3, 3, {16'($urandom_range(0, 65535)), 16'h0000} & 32'hFFFF_FFF8,
               1'b0, 1'b0);
    queue_load(256, 0, $urandom, 1'b0, 1'b0);     // empty end code
    queue_load(511, 5, $urandom, 1'b0, 1'b0);     // index past the table, dropped
    queue_raw(random_req(ReqUnused), 1'b0, 1'b0); // unknown request, dropped
    queue_encode(0, 1'b0, 1'b0);
    queue_encode(255, 1'b0, 1'b0);
    queue_encode(1, 1'b0, 1'b0);
    queue_encode(2, 1'b0, 1'b0);
    queue_encode(3, 1'b0, 1'b0);
    queue_end(1'b0, 1'b0);                        // flush of a partial byte
    queue_end(1'b0, 1'b0);                        // nothing pending: empty end
    queue_encode(3, 1'b0, 1'b0);
    queue_end(1'b0, 1'b0);                        // pending bits all zero
    queue_load(256, 8, 32'h0000_005A, 1'b0, 1'b0);
    queue_encode(0, 1'b0, 1'b0);
    queue_end(1'b0, 1'b0);                        // end code completes a byte
    queue_load(256, 32, 32'h8000_0001, 1'b0, 1'b0);
    queue_encode(255, 1'b0, 1'b0);
    queue_end(1'b0, 1'b0);

    // Random part: mostly encodes of loaded symbols with a steady trickle of
    // table updates and stream ends, plus some ignored noise.
    counted = 0;
    while (counted < RandBeats) begin
      roll  = $urandom_range(0, 99);
      quiet = (counted >= RandBeats - QuietTail);
      drain = (counted % 70 == 69);
      if (roll < 5) begin
        if (roll < 2) begin
          r = random_req(ReqUnused);
        end else begin
          r = random_req(hcbp_pkg::REQ_LOAD);
          r.entry_index = 9'($urandom_range(hcbp_pkg::TableEntries, 511));
        end
        queue_raw(r, 1'b0, quiet);
      end else if (roll < 20) begin
        queue_load($urandom_range(0, hcbp_pkg::TableEntries - 1), random_code_len(),
                   $urandom, drain, quiet);
        counted++;
      end else if (roll < 32) begin
        queue_end(drain, quiet);
        counted++;
      end else begin
        queue_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     drain, quiet);
        counted++;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to go in and every predicted byte to come out, then
    // give the block time to show any stray output.
    while (beat_queue.size() != 0 || start || expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_bytes.size() != 0) begin
      note_mismatch($sformatf("%0d expected beats never arrived", expected_bytes.size()));
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
